### hdl/csal_pkg.sv
// csal_pkg: shared types and constants of the cursor shape to argb layer converter
// used by every module of the block but csal_chk, no dependencies
`default_nettype none

package csal_pkg;

    localparam int C_MAX_WIDTH = 256;
    localparam int C_Q_DEPTH   = 4;
    localparam int C_Q_AW      = $clog2(C_Q_DEPTH);

    localparam logic [1:0] C_MODE_MONO   = 2'd0;
    localparam logic [1:0] C_MODE_COLOR  = 2'd1;
    localparam logic [1:0] C_MODE_MASKED = 2'd2;

    localparam logic [1:0] C_REG_MODE  = 2'd0;
    localparam logic [1:0] C_REG_LAYER = 2'd1;
    localparam logic [1:0] C_REG_WIDTH = 2'd2;
    localparam logic [1:0] C_REG_ITEMS = 2'd3;

    localparam logic [31:0] C_PIX_BLACK = 32'hFF00_0000;
    localparam logic [31:0] C_PIX_WHITE = 32'hFFFF_FFFF;
    localparam logic [31:0] C_PIX_CLEAR = 32'h0000_0000;
    localparam logic [7:0]  C_ALPHA_ON  = 8'hFF;
    localparam logic [7:0]  C_ALPHA_OFF = 8'h00;

    typedef struct packed {
        logic [1:0]  mode;
        logic        layer;
        logic [8:0]  width;
        logic [10:0] items;
    } t_cfg;

    typedef struct packed {
        logic        mono;
        logic        layer;
        logic [3:0]  cnt;
        logic [7:0]  and_b;
        logic [7:0]  xor_b;
        logic [31:0] pix;
        logic        bad;
    } t_job;

endpackage

`default_nettype wire

### hdl/csal_cfg.sv
// csal_cfg: apb register file holding mode, layer, width and row pitch
// depends on csal_pkg
`default_nettype none

module csal_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output csal_pkg::t_cfg     o_cfg,
    output logic               o_wr
);
    import csal_pkg::*;

    t_cfg       r_cfg;
    logic       wr;
    logic [1:0] idx;

    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;
    assign o_wr   = wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= C_MODE_MONO;
            r_cfg.layer <= 1'b0;
            r_cfg.width <= 9'd32;
            r_cfg.items <= 11'd4;
        end else if (wr) begin
            unique case (idx)
                C_REG_MODE:  r_cfg.mode  <= pwdata[1:0];
                C_REG_LAYER: r_cfg.layer <= pwdata[0];
                C_REG_WIDTH: r_cfg.width <= pwdata[8:0];
                C_REG_ITEMS: r_cfg.items <= pwdata[10:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            C_REG_MODE:  prdata = {30'd0, r_cfg.mode};
            C_REG_LAYER: prdata = {31'd0, r_cfg.layer};
            C_REG_WIDTH: prdata = {23'd0, r_cfg.width};
            C_REG_ITEMS: prdata = {21'd0, r_cfg.items};
        endcase
    end

endmodule

`default_nettype wire

### hdl/csal_front.sv
// csal_front: accepts source items, tracks row position and builds pixel jobs
// depends on csal_pkg
`default_nettype none

module csal_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire csal_pkg::t_cfg i_cfg,
    input  wire logic           i_cfg_wr,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_and_bits,
    input  wire logic [7:0]     i_xor_bits,
    input  wire logic [31:0]    i_color_pixel,
    input  wire logic           i_q_full,
    output logic                o_push,
    output csal_pkg::t_job      o_job
);
    import csal_pkg::*;

    logic [9:0]  r_row_idx;
    logic [9:0]  n_row_idx;
    logic [10:0] nxt;
    logic [8:0]  width_sat;
    logic [12:0] start;
    logic [12:0] diff;
    logic [3:0]  mono_cnt;
    logic [7:0]  alpha;
    logic        job_ok;
    logic        accept;
    t_job        job;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign alpha   = i_color_pixel[31:24];

    assign width_sat = (32'(i_cfg.width) > 32'(C_MAX_WIDTH)) ? 9'(C_MAX_WIDTH) : i_cfg.width;
    assign start     = {r_row_idx, 3'b000};
    assign diff      = 13'(width_sat) - start;

    always_comb begin
        if (13'(width_sat) <= start) begin
            mono_cnt = 4'd0;
        end else if (diff > 13'd8) begin
            mono_cnt = 4'd8;
        end else begin
            mono_cnt = diff[3:0];
        end
    end

    always_comb begin
        job.mono  = 1'b0;
        job.layer = i_cfg.layer;
        job.cnt   = 4'd1;
        job.and_b = i_and_bits;
        job.xor_b = i_xor_bits;
        job.pix   = i_color_pixel;
        job.bad   = 1'b0;
        job_ok    = 1'b0;
        unique case (i_cfg.mode)
            C_MODE_MONO: begin
                job.mono = 1'b1;
                job.cnt  = mono_cnt;
                job_ok   = (mono_cnt != 4'd0);
            end
            C_MODE_COLOR: begin
                job_ok = !i_cfg.layer;
            end
            C_MODE_MASKED: begin
                job_ok = 1'b1;
                if (i_cfg.layer) begin
                    if (alpha == C_ALPHA_OFF) begin
                        job.pix = C_PIX_CLEAR;
                    end else if (alpha != C_ALPHA_ON) begin
                        job.bad = 1'b1;
                    end
                end else begin
                    if (alpha == C_ALPHA_ON) begin
                        job.pix = C_PIX_CLEAR;
                    end else if (alpha == C_ALPHA_OFF) begin
                        job.pix = i_color_pixel | C_PIX_BLACK;
                    end else begin
                        job.bad = 1'b1;
                    end
                end
            end
            default: begin
                job_ok = 1'b0;
            end
        endcase
    end

    assign o_push = accept && job_ok;
    assign o_job  = job;

    // row wraps once the next position reaches the pitch
    assign nxt = 11'(r_row_idx) + 11'd1;

    always_comb begin
        n_row_idx = r_row_idx;
        if (i_cfg_wr) begin
            n_row_idx = 10'd0;
        end else if (accept && i_cfg.mode == C_MODE_MONO) begin
            n_row_idx = (nxt >= i_cfg.items) ? 10'd0 : nxt[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_idx <= 10'd0;
        end else begin
            r_row_idx <= n_row_idx;
        end
    end

endmodule

`default_nettype wire

### hdl/csal_fifo.sv
// csal_fifo: short job queue between the front and the back
// depends on csal_pkg
`default_nettype none

module csal_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire csal_pkg::t_job i_job,
    input  wire logic           i_pop,
    output csal_pkg::t_job      o_head,
    output logic                o_full,
    output logic                o_empty
);
    import csal_pkg::*;

    t_job              r_mem [C_Q_DEPTH];
    logic [C_Q_AW-1:0] r_wr_ptr;
    logic [C_Q_AW-1:0] r_rd_ptr;
    logic [C_Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (C_Q_AW+1)'(C_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == C_Q_AW'(C_Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == C_Q_AW'(C_Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/csal_back.sv
// csal_back: expands queued jobs into pixels, one transfer per cycle while i_ready is high
// depends on csal_pkg
`default_nettype none

module csal_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire csal_pkg::t_job i_head,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [31:0]         o_pixel,
    output logic                o_last,
    output logic                o_bad
);
    import csal_pkg::*;

    logic [2:0]  r_pos;
    logic        r_valid;
    logic [31:0] r_pixel;
    logic        r_last;
    logic        r_bad;
    logic        advance;
    logic        load;
    logic        last;
    logic [2:0]  sh;
    logic        a_bit;
    logic        x_bit;
    logic [31:0] pix;

    assign advance = !r_valid || i_ready;
    assign load    = advance && !i_empty;
    assign last    = ({1'b0, r_pos} + 4'd1) == i_head.cnt;
    assign o_pop   = load && last;

    // msb is the leftmost column
    assign sh    = 3'd7 - r_pos;
    assign a_bit = i_head.and_b[sh];
    assign x_bit = i_head.xor_b[sh];

    always_comb begin
        if (!i_head.mono) begin
            pix = i_head.pix;
        end else if (i_head.layer) begin
            pix = (a_bit && x_bit) ? C_PIX_WHITE : C_PIX_CLEAR;
        end else begin
            unique case ({x_bit, a_bit})
                2'b00:   pix = C_PIX_BLACK;
                2'b10:   pix = C_PIX_WHITE;
                default: pix = C_PIX_CLEAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else if (advance) begin
            r_valid <= !i_empty;
            if (load) begin
                r_pos <= last ? 3'd0 : r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel <= pix;
            r_last  <= last;
            r_bad   <= i_head.bad;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;
    assign o_bad   = r_bad;

endmodule

`default_nettype wire

### hdl/cursor_shape_to_argb_layers_unit.sv
// cursor_shape_to_argb_layers_unit: top level of the cursor shape converter
// depends on csal_pkg, csal_cfg, csal_front, csal_fifo, csal_back
`default_nettype none

// Turns a cursor shape into one 32-bit ARGB layer (alpha or xor, per
// layer_select). The result port carries one pixel transfer per cycle
// while m_tready is high. A monochrome mask byte yields up to 8 pixels
// (none in the row padding); a color item yields one, none in color mode
// with layer set. The front accepts an item every cycle while the 4-entry
// job queue has room, so input rate is set by the result port. Items pass
// the job queue, then the output register. The user must write registers
// through the APB port only while the block is idle; the block does not
// enforce this. Any write restarts the row position.
module cursor_shape_to_argb_layers_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // and_bits[7:0], xor_bits[15:8], color_pixel[47:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // out_pixel[31:0]
    output logic             m_tlast,
    output logic             m_tuser    // bad_alpha[0]
);
    import csal_pkg::*;

    t_cfg cfg;
    logic cfg_wr;
    logic push;
    t_job job;
    logic pop;
    t_job head;
    logic q_full;
    logic q_empty;

    csal_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_wr    (cfg_wr)
    );

    csal_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cfg_wr      (cfg_wr),
        .i_valid       (s_tvalid),
        .o_ready       (s_tready),
        .i_and_bits    (s_tdata[7:0]),
        .i_xor_bits    (s_tdata[15:8]),
        .i_color_pixel (s_tdata[47:16]),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (job)
    );

    csal_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    csal_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_pixel (m_tdata),
        .o_last  (m_tlast),
        .o_bad   (m_tuser)
    );

endmodule

`default_nettype wire

### hdl/csal_chk.sv
// csal_chk: port-level checks of the cursor shape converter, bound to the top level
// depends on cursor_shape_to_argb_layers_unit
`default_nettype none

module csal_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // a flagged pixel comes from a single-pixel color item
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("bad_alpha on a pixel that is not last");

    // flagged pixel keeps its partial alpha
    a_bad_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[31:24] != 8'h00 && m_tdata[31:24] != 8'hFF))
        else $error("bad_alpha with full or empty alpha");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind cursor_shape_to_argb_layers_unit csal_chk u_csal_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
